// ===== design/c65eu_pkg.sv =====
// Shared types and constants for the 6502 execute unit.
package c65eu_pkg;

    typedef enum logic [4:0] {
        K_NOP, K_ORA, K_AND, K_EOR, K_ADC, K_STA, K_LDA, K_CMP, K_SBC,
        K_BRANCH, K_RMW_MEM, K_RMW_ACC, K_STY, K_STX, K_LDY, K_LDX,
        K_CPX, K_CPY, K_BIT, K_FLAG, K_TAX, K_TAY, K_TSX, K_TXA, K_TYA,
        K_TXS, K_INX, K_DEX, K_INY, K_DEY, K_PUSH, K_PULL
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] sub;
        logic [7:0] op;
        logic [7:0] operand;
    } uop_t;

    localparam logic [7:0] FLAGS_RESET = 8'h24;
    localparam logic [7:0] SP_RESET    = 8'hFD;
    localparam int         FLAG_C = 0;
    localparam int         FLAG_Z = 1;
    localparam int         FLAG_I = 2;
    localparam int         FLAG_D = 3;
    localparam int         FLAG_B = 4;
    localparam int         FLAG_U = 5;
    localparam int         FLAG_V = 6;
    localparam int         FLAG_N = 7;

endpackage

// ===== design/c65eu_decode.sv =====
// Front end: opcode classification into a micro-op.
module c65eu_decode
(
    input  logic [7:0]       op,
    input  logic [7:0]       operand,
    output c65eu_pkg::uop_t  uop
);

    always_comb
    begin
        uop.op      = op;
        uop.operand = operand;
        uop.sub     = op[7:5];
        uop.kind    = c65eu_pkg::K_NOP;
        if (op[1:0] == 2'b01 && op != 8'h89)
        begin
            case (op[7:5])
                3'd0:    uop.kind = c65eu_pkg::K_ORA;
                3'd1:    uop.kind = c65eu_pkg::K_AND;
                3'd2:    uop.kind = c65eu_pkg::K_EOR;
                3'd3:    uop.kind = c65eu_pkg::K_ADC;
                3'd4:    uop.kind = c65eu_pkg::K_STA;
                3'd5:    uop.kind = c65eu_pkg::K_LDA;
                3'd6:    uop.kind = c65eu_pkg::K_CMP;
                default: uop.kind = c65eu_pkg::K_SBC;
            endcase
        end
        else if (op[4:0] == 5'h10)
        begin
            uop.kind = c65eu_pkg::K_BRANCH;
        end
        else
        begin
            case (op)
                8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2E, 8'h36, 8'h3E,
                8'h46, 8'h4E, 8'h56, 8'h5E, 8'h66, 8'h6E, 8'h76, 8'h7E,
                8'hC6, 8'hCE, 8'hD6, 8'hDE, 8'hE6, 8'hEE, 8'hF6, 8'hFE:
                    uop.kind = c65eu_pkg::K_RMW_MEM;
                8'h0A, 8'h2A, 8'h4A, 8'h6A: uop.kind = c65eu_pkg::K_RMW_ACC;
                8'h84, 8'h8C, 8'h94: uop.kind = c65eu_pkg::K_STY;
                8'h86, 8'h8E, 8'h96: uop.kind = c65eu_pkg::K_STX;
                8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: uop.kind = c65eu_pkg::K_LDY;
                8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: uop.kind = c65eu_pkg::K_LDX;
                8'hE0, 8'hE4, 8'hEC: uop.kind = c65eu_pkg::K_CPX;
                8'hC0, 8'hC4, 8'hCC: uop.kind = c65eu_pkg::K_CPY;
                8'h24, 8'h2C: uop.kind = c65eu_pkg::K_BIT;
                8'h18, 8'h38, 8'h58, 8'h78, 8'hB8, 8'hD8, 8'hF8:
                    uop.kind = c65eu_pkg::K_FLAG;
                8'hAA: uop.kind = c65eu_pkg::K_TAX;
                8'hA8: uop.kind = c65eu_pkg::K_TAY;
                8'hBA: uop.kind = c65eu_pkg::K_TSX;
                8'h8A: uop.kind = c65eu_pkg::K_TXA;
                8'h98: uop.kind = c65eu_pkg::K_TYA;
                8'h9A: uop.kind = c65eu_pkg::K_TXS;
                8'hE8: uop.kind = c65eu_pkg::K_INX;
                8'hCA: uop.kind = c65eu_pkg::K_DEX;
                8'hC8: uop.kind = c65eu_pkg::K_INY;
                8'h88: uop.kind = c65eu_pkg::K_DEY;
                8'h48, 8'h08: uop.kind = c65eu_pkg::K_PUSH;
                8'h68, 8'h28: uop.kind = c65eu_pkg::K_PULL;
                default: uop.kind = c65eu_pkg::K_NOP;
            endcase
        end
    end

endmodule

// ===== design/c65eu_queue.sv =====
// Two-entry queue of decoded micro-ops between front and back end.
module c65eu_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  c65eu_pkg::uop_t  in_uop,
    output logic             out_valid,
    input  logic             out_ready,
    output c65eu_pkg::uop_t  out_uop
);

    c65eu_pkg::uop_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_uop   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_uop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== design/c65eu_execute.sv =====
// Back end: register file, ALU, flags and the registered result.
module c65eu_execute
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             decimal_enable,
    input  logic             in_valid,
    output logic             in_ready,
    input  c65eu_pkg::uop_t  uop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [57:0]      result
);

    logic [7:0] acc_reg, x_reg, y_reg, sp_reg, flags_reg;
    logic [7:0] acc_next, x_next, y_next, sp_next, flags_next;
    logic [7:0] wd, slot;
    logic       we, br;
    logic       valid_reg;
    logic [57:0] result_reg;
    logic       fire;

    logic [7:0] m, rmw_in, rmw_out, cmp_r;
    logic       c_in, bcd;
    logic [8:0] bsum, ssum, dt, dt2;
    logic [7:0] inv;
    logic [4:0] dlo;
    logic [5:0] slo;
    logic [9:0] st;
    logic [8:0] cmp_d;
    logic       flag_sel;

    assign in_ready = !valid_reg || out_ready;
    assign fire     = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign result    = result_reg;

    assign m    = uop.operand;
    assign c_in = flags_reg[c65eu_pkg::FLAG_C];
    assign bcd  = decimal_enable && flags_reg[c65eu_pkg::FLAG_D];
    assign inv  = ~m;
    assign bsum = {1'b0, acc_reg} + {1'b0, m} + {8'd0, c_in};
    assign ssum = {1'b0, acc_reg} + {1'b0, inv} + {8'd0, c_in};

    // Decimal ADC adjust
    always_comb
    begin
        logic [4:0] lo0;
        lo0 = {1'b0, acc_reg[3:0]} + {1'b0, m[3:0]} + {4'd0, c_in};
        if (lo0 >= 5'd10)
            dlo = {1'b1, 4'(lo0[3:0] + 4'd6)};
        else
            dlo = lo0;
        dt  = {1'b0, acc_reg[7:4], 4'd0} + {1'b0, m[7:4], 4'd0} + {4'd0, dlo};
        dt2 = (dt >= 9'h0A0) ? dt + 9'h060 : dt;
    end

    // Decimal SBC adjust, two's complement 10-bit
    always_comb
    begin
        logic [5:0] lo0;
        lo0 = {2'b0, acc_reg[3:0]} - {2'b0, m[3:0]} + {5'd0, c_in} - 6'd1;
        if (lo0[5])
            slo = {2'b11, 4'(lo0[3:0] + 4'd10)};
        else
            slo = lo0;
        st = {2'b0, acc_reg[7:4], 4'd0} - {2'b0, m[7:4], 4'd0}
           + {{4{slo[5]}}, slo};
        if (st[9]) st = st - 10'h060;
    end

    always_comb
    begin
        case (uop.kind)
            c65eu_pkg::K_CPX: cmp_r = x_reg;
            c65eu_pkg::K_CPY: cmp_r = y_reg;
            default:          cmp_r = acc_reg;
        endcase
        cmp_d = {1'b0, cmp_r} - {1'b0, m};
        rmw_in = (uop.kind == c65eu_pkg::K_RMW_ACC) ? acc_reg : m;
        case (uop.sub)
            3'd0:    rmw_out = {rmw_in[6:0], 1'b0};
            3'd1:    rmw_out = {rmw_in[6:0], c_in};
            3'd2:    rmw_out = {1'b0, rmw_in[7:1]};
            3'd3:    rmw_out = {c_in, rmw_in[7:1]};
            3'd6:    rmw_out = rmw_in - 8'd1;
            default: rmw_out = rmw_in + 8'd1;
        endcase
        case (uop.op[7:6])
            2'd0:    flag_sel = flags_reg[c65eu_pkg::FLAG_N];
            2'd1:    flag_sel = flags_reg[c65eu_pkg::FLAG_V];
            2'd2:    flag_sel = flags_reg[c65eu_pkg::FLAG_C];
            default: flag_sel = flags_reg[c65eu_pkg::FLAG_Z];
        endcase
    end

    always_comb
    begin
        logic [7:0] nz;
        logic       set_nz;
        acc_next = acc_reg;
        x_next = x_reg;
        y_next = y_reg;
        sp_next = sp_reg;
        flags_next = flags_reg;
        wd = 8'd0;
        we = 1'b0;
        slot = 8'd0;
        br = 1'b0;
        nz = 8'd0;
        set_nz = 1'b0;
        case (uop.kind)
            c65eu_pkg::K_ORA: begin acc_next = acc_reg | m; nz = acc_next; set_nz = 1'b1; end
            c65eu_pkg::K_AND: begin acc_next = acc_reg & m; nz = acc_next; set_nz = 1'b1; end
            c65eu_pkg::K_EOR: begin acc_next = acc_reg ^ m; nz = acc_next; set_nz = 1'b1; end
            c65eu_pkg::K_LDA: begin acc_next = m; nz = m; set_nz = 1'b1; end
            c65eu_pkg::K_STA: begin wd = acc_reg; we = 1'b1; end
            c65eu_pkg::K_ADC:
            begin
                if (bcd)
                begin
                    flags_next[c65eu_pkg::FLAG_Z] = (bsum[7:0] == 8'd0);
                    flags_next[c65eu_pkg::FLAG_N] = dt[7];
                    flags_next[c65eu_pkg::FLAG_V] = (acc_reg[7] ^ dt[7]) & (m[7] ^ dt[7]);
                    flags_next[c65eu_pkg::FLAG_C] = dt2[8] || (dt >= 9'h0A0);
                    acc_next = dt2[7:0];
                end
                else
                begin
                    flags_next[c65eu_pkg::FLAG_C] = bsum[8];
                    flags_next[c65eu_pkg::FLAG_V] =
                        (acc_reg[7] ^ bsum[7]) & (m[7] ^ bsum[7]);
                    acc_next = bsum[7:0];
                    nz = bsum[7:0];
                    set_nz = 1'b1;
                end
            end
            c65eu_pkg::K_SBC:
            begin
                flags_next[c65eu_pkg::FLAG_C] = ssum[8];
                flags_next[c65eu_pkg::FLAG_V] =
                    (acc_reg[7] ^ ssum[7]) & (inv[7] ^ ssum[7]);
                nz = ssum[7:0];
                set_nz = 1'b1;
                acc_next = bcd ? st[7:0] : ssum[7:0];
            end
            c65eu_pkg::K_CMP, c65eu_pkg::K_CPX, c65eu_pkg::K_CPY:
            begin
                flags_next[c65eu_pkg::FLAG_C] = !cmp_d[8];
                flags_next[c65eu_pkg::FLAG_Z] = (cmp_r == m);
                flags_next[c65eu_pkg::FLAG_N] = cmp_d[7];
            end
            c65eu_pkg::K_BRANCH: br = (flag_sel == uop.op[5]);
            c65eu_pkg::K_RMW_MEM, c65eu_pkg::K_RMW_ACC:
            begin
                if (uop.sub == 3'd0 || uop.sub == 3'd1)
                    flags_next[c65eu_pkg::FLAG_C] = rmw_in[7];
                else if (uop.sub == 3'd2 || uop.sub == 3'd3)
                    flags_next[c65eu_pkg::FLAG_C] = rmw_in[0];
                nz = rmw_out;
                set_nz = 1'b1;
                if (uop.kind == c65eu_pkg::K_RMW_ACC)
                    acc_next = rmw_out;
                else
                begin
                    wd = rmw_out;
                    we = 1'b1;
                end
            end
            c65eu_pkg::K_STY: begin wd = y_reg; we = 1'b1; end
            c65eu_pkg::K_STX: begin wd = x_reg; we = 1'b1; end
            c65eu_pkg::K_LDY: begin y_next = m; nz = m; set_nz = 1'b1; end
            c65eu_pkg::K_LDX: begin x_next = m; nz = m; set_nz = 1'b1; end
            c65eu_pkg::K_BIT:
            begin
                flags_next[c65eu_pkg::FLAG_Z] = ((acc_reg & m) == 8'd0);
                flags_next[7:6] = m[7:6];
            end
            c65eu_pkg::K_FLAG:
            begin
                case (uop.op[7:5])
                    3'd0: flags_next[c65eu_pkg::FLAG_C] = 1'b0;
                    3'd1: flags_next[c65eu_pkg::FLAG_C] = 1'b1;
                    3'd2: flags_next[c65eu_pkg::FLAG_I] = 1'b0;
                    3'd3: flags_next[c65eu_pkg::FLAG_I] = 1'b1;
                    3'd5: flags_next[c65eu_pkg::FLAG_V] = 1'b0;
                    3'd6: flags_next[c65eu_pkg::FLAG_D] = 1'b0;
                    3'd7: flags_next[c65eu_pkg::FLAG_D] = 1'b1;
                    default: flags_next = flags_reg;
                endcase
            end
            c65eu_pkg::K_TAX: begin x_next = acc_reg; nz = acc_reg; set_nz = 1'b1; end
            c65eu_pkg::K_TAY: begin y_next = acc_reg; nz = acc_reg; set_nz = 1'b1; end
            c65eu_pkg::K_TSX: begin x_next = sp_reg; nz = sp_reg; set_nz = 1'b1; end
            c65eu_pkg::K_TXA: begin acc_next = x_reg; nz = x_reg; set_nz = 1'b1; end
            c65eu_pkg::K_TYA: begin acc_next = y_reg; nz = y_reg; set_nz = 1'b1; end
            c65eu_pkg::K_TXS: sp_next = x_reg;
            c65eu_pkg::K_INX: begin x_next = x_reg + 8'd1; nz = x_next; set_nz = 1'b1; end
            c65eu_pkg::K_DEX: begin x_next = x_reg - 8'd1; nz = x_next; set_nz = 1'b1; end
            c65eu_pkg::K_INY: begin y_next = y_reg + 8'd1; nz = y_next; set_nz = 1'b1; end
            c65eu_pkg::K_DEY: begin y_next = y_reg - 8'd1; nz = y_next; set_nz = 1'b1; end
            c65eu_pkg::K_PUSH:
            begin
                // PHA is 0x48, PHP 0x08
                wd = uop.op[6] ? acc_reg : (flags_reg | 8'h10);
                we = 1'b1;
                slot = sp_reg;
                sp_next = sp_reg - 8'd1;
            end
            c65eu_pkg::K_PULL:
            begin
                sp_next = sp_reg + 8'd1;
                slot = sp_next;
                if (uop.op[6])
                begin
                    acc_next = m;
                    nz = m;
                    set_nz = 1'b1;
                end
                else
                    flags_next = m | 8'h20;
            end
            default: ;
        endcase
        if (set_nz)
        begin
            flags_next[c65eu_pkg::FLAG_Z] = (nz == 8'd0);
            flags_next[c65eu_pkg::FLAG_N] = nz[7];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= 8'd0;
            x_reg     <= 8'd0;
            y_reg     <= 8'd0;
            sp_reg    <= c65eu_pkg::SP_RESET;
            flags_reg <= c65eu_pkg::FLAGS_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                acc_reg   <= acc_next;
                x_reg     <= x_next;
                y_reg     <= y_next;
                sp_reg    <= sp_next;
                flags_reg <= flags_next;
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= {sp_next, y_next, x_next, acc_next, flags_next, br, slot, we, wd};
        end
    end

endmodule

// ===== design/cpu6502_execute_unit.sv =====
// Top level of the 6502 execute unit: decode, queue and execute.
//
//  channel   direction  payload
//  s_axis    in         tdata = op[7:0], operand[15:8]
//  m_axis    out        tdata = write_data .. sp_out, 58 bits padded to 64
//  cfg       in         cfg_data = decimal_enable
//
// One opcode per cycle sustained while m_axis accepts results; each passes
// from request to result through the queue write, then the register-file update with the output register.
// Reset clears A, X, Y, sets SP to 0xFD and flags to 0x24, decimal on.
// A stall on m_axis fills the output register and the two-entry queue, then
// holds s_axis_tready low.
module cpu6502_execute_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // op, operand
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // write_data, write_enable, stack_slot,
                                        // branch_taken, status_out, acc_out,
                                        // x_out, y_out, sp_out, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    c65eu_pkg::uop_t dec_uop, q_uop;
    logic            q_valid, q_ready;
    logic            decimal_enable_reg;
    logic [57:0]     result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decimal_enable_reg <= 1'b1;
        else if (cfg_valid)
            decimal_enable_reg <= cfg_data;
    end

    c65eu_decode u_decode
    (
        .op      (s_axis_tdata[7:0]),
        .operand (s_axis_tdata[15:8]),
        .uop     (dec_uop)
    );

    c65eu_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_uop    (dec_uop),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_uop   (q_uop)
    );

    c65eu_execute u_execute
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .decimal_enable (decimal_enable_reg),
        .in_valid       (q_valid),
        .in_ready       (q_ready),
        .uop            (q_uop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .result         (result)
    );

    assign m_axis_tdata = {6'd0, result};

endmodule
